>>> rtl/core/sst_pkg.sv
package sst_pkg;

    // Fixed widths of the channel fields
    localparam int KEY_BITS   = 32;
    localparam int POS_BITS   = 6;
    localparam int TOTAL_BITS = 7;

    typedef enum logic [1:0] {
        ACT_INSERT   = 2'd0,
        ACT_ERASE    = 2'd1,
        ACT_CONTAINS = 2'd2,
        ACT_GET      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_UPD  = 1'b1
    } state_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic capture;
        logic shift_up;
        logic shift_down;
    } cell_ctl_t;

endpackage

>>> rtl/core/sst_if.sv
interface sst_req_if;
    logic                             valid;
    logic                             ready;
    sst_pkg::action_t                 action;
    logic [sst_pkg::KEY_BITS-1:0]     key;
    logic [sst_pkg::POS_BITS-1:0]     position;

    modport source (output valid, action, key, position, input ready);
    modport sink   (input valid, action, key, position, output ready);
endinterface

interface sst_rsp_if;
    logic                             valid;
    logic                             ready;
    sst_pkg::status_t                 status;
    logic [sst_pkg::KEY_BITS-1:0]     read_key;
    logic [sst_pkg::TOTAL_BITS-1:0]   entry_total;

    modport source (output valid, status, read_key, entry_total, input ready);
    modport sink   (input valid, status, read_key, entry_total, output ready);
endinterface

>>> rtl/core/sst_cell.sv
module sst_cell #(
    parameter int KW  = 32,
    parameter int IDX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sst_pkg::cell_ctl_t            ctl,
    input  logic [KW-1:0]                 cmp_key,
    input  logic [sst_pkg::POS_BITS-1:0]  cmp_pos,
    input  logic [KW-1:0]                 ins_key,
    input  logic [KW-1:0]                 left_key,
    input  logic                          left_occ,
    input  logic                          left_lt,
    input  logic [KW-1:0]                 right_key,
    input  logic                          right_occ,
    output logic [KW-1:0]                 key,
    output logic                          occ,
    output logic                          lt,
    output logic                          eq,
    output logic                          sel
);

    // Only cells whose index fits the position field can be picked by get
    localparam bit REACH = IDX < (1 << sst_pkg::POS_BITS);
    localparam logic [sst_pkg::POS_BITS-1:0] MY_POS = sst_pkg::POS_BITS'(IDX);

    logic [KW-1:0] key_reg, key_next;
    logic          occ_reg, occ_next;
    logic          lt_reg, lt_next;
    logic          eq_reg, eq_next;
    logic          sel_reg, sel_next;

    always_comb
    begin
        key_next = key_reg;
        occ_next = occ_reg;
        // Cells at or after the sorted place move; on insert the first of them takes the new key
        if (ctl.shift_up && !lt_reg)
        begin
            if (left_lt)
            begin
                key_next = ins_key;
                occ_next = 1'b1;
            end
            else
            begin
                key_next = left_key;
                occ_next = left_occ;
            end
        end
        else if (ctl.shift_down && !lt_reg)
        begin
            key_next = right_key;
            occ_next = right_occ;
        end
    end

    always_comb
    begin
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        sel_next = sel_reg;
        if (ctl.capture)
        begin
            lt_next  = occ_reg && (key_reg < cmp_key);
            eq_next  = occ_reg && (key_reg == cmp_key);
            sel_next = REACH && occ_reg && (cmp_pos == MY_POS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
        sel_reg <= sel_next;
    end

    assign key = key_reg;
    assign occ = occ_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;
    assign sel = sel_reg;

endmodule

>>> rtl/core/sorted_set_table_top.sv
// Sorted set table: holds up to CAPACITY distinct keys in ascending order.
// Channels: req (sink) carries action, key and position; rsp (source) carries
// status, read_key and entry_total. Every request beat gives exactly one
// response beat. Keys are taken modulo 2^KW, KW being KEY_WIDTH capped at KEY_BITS.
// For each request, in the accept cycle every cell compares its key and index
// with the request and registers the result; in the update state the
// controller reduces those flags and the cells shift one place toward their
// neighbor for insert or erase, and the response register loads. A new
// request is accepted only once the previous one has committed and the
// controller is idle again.
// The response register frees the input side: a new request is taken while
// the previous response still waits. If the receiver stalls, the finished
// update waits in the update state until the response register is free, and
// the table holds.
// Reset clears the occupancy bits and the count, leaving an empty set; no
// clearing pass is needed, and reset is asynchronous and active low.
module sorted_set_table_top #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    sst_req_if.sink    req,
    sst_rsp_if.source  rsp
);

    localparam int KW = (KEY_WIDTH < sst_pkg::KEY_BITS) ? KEY_WIDTH : sst_pkg::KEY_BITS;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    sst_pkg::state_t    state_reg, state_next;
    sst_pkg::cell_ctl_t ctl;

    sst_pkg::action_t   act_reg, act_next;
    logic [KW-1:0]      key_reg, key_next;
    logic [CW-1:0]      count_reg, count_next;

    logic                              out_valid_reg, out_valid_next;
    sst_pkg::status_t                  status_reg, status_next;
    logic [sst_pkg::KEY_BITS-1:0]      read_reg, read_next;
    logic [sst_pkg::TOTAL_BITS-1:0]    total_reg, total_next;

    logic [KW-1:0]       cell_key [CAPACITY];
    logic [KW-1:0]       nb_left_key [CAPACITY];
    logic [KW-1:0]       nb_right_key [CAPACITY];
    logic [CAPACITY-1:0] cell_occ, cell_lt, cell_eq, cell_sel;
    logic [CAPACITY-1:0] nb_left_occ, nb_left_lt, nb_right_occ;

    logic          out_free;
    logic          commit;
    logic          present;
    logic          found;
    logic          full;
    logic [KW-1:0] found_key;
    logic [KW-1:0] port_key;

    assign port_key = req.key[KW-1:0];

    // Neighbor wiring of the cell row
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_row
        if (g == 0)
        begin : g_first
            assign nb_left_key[g] = key_reg;
            assign nb_left_occ[g] = 1'b1;
            assign nb_left_lt[g]  = 1'b1;
        end
        else
        begin : g_mid_l
            assign nb_left_key[g] = cell_key[g-1];
            assign nb_left_occ[g] = cell_occ[g-1];
            assign nb_left_lt[g]  = cell_lt[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign nb_right_key[g] = cell_key[g];
            assign nb_right_occ[g] = 1'b0;
        end
        else
        begin : g_mid_r
            assign nb_right_key[g] = cell_key[g+1];
            assign nb_right_occ[g] = cell_occ[g+1];
        end

        sst_cell #(
            .KW  (KW),
            .IDX (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .cmp_key   (port_key),
            .cmp_pos   (req.position),
            .ins_key   (key_reg),
            .left_key  (nb_left_key[g]),
            .left_occ  (nb_left_occ[g]),
            .left_lt   (nb_left_lt[g]),
            .right_key (nb_right_key[g]),
            .right_occ (nb_right_occ[g]),
            .key       (cell_key[g]),
            .occ       (cell_occ[g]),
            .lt        (cell_lt[g]),
            .eq        (cell_eq[g]),
            .sel       (cell_sel[g])
        );
    end

    // Reduce the per-cell flags
    assign present = |cell_eq;
    assign found   = |cell_sel;
    assign full    = cell_occ[CAPACITY-1];

    always_comb
    begin
        found_key = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found_key = found_key | (cell_key[i] & {KW{cell_sel[i]}});
        end
    end

    assign out_free = !out_valid_reg || rsp.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sst_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = sst_pkg::S_UPD;
                end
            end
            sst_pkg::S_UPD:
            begin
                if (out_free)
                begin
                    state_next = sst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sst_pkg::S_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        req.ready = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            sst_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
            end
            sst_pkg::S_UPD:
            begin
                commit = out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign ctl.capture    = req.valid && req.ready;
    assign ctl.shift_up   = commit && (act_reg == sst_pkg::ACT_INSERT) && !present && !full;
    assign ctl.shift_down = commit && (act_reg == sst_pkg::ACT_ERASE) && present;

    always_comb
    begin
        act_next = act_reg;
        key_next = key_reg;
        if (ctl.capture)
        begin
            act_next = req.action;
            key_next = port_key;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.shift_up)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.shift_down)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // Result of the request being committed
    always_comb
    begin
        status_next = sst_pkg::ST_MISS;
        read_next   = '0;
        case (act_reg)
            sst_pkg::ACT_INSERT:
            begin
                if (present)
                begin
                    status_next = sst_pkg::ST_MISS;
                end
                else if (full)
                begin
                    status_next = sst_pkg::ST_FULL;
                end
                else
                begin
                    status_next = sst_pkg::ST_OK;
                end
            end
            sst_pkg::ACT_ERASE,
            sst_pkg::ACT_CONTAINS:
            begin
                status_next = present ? sst_pkg::ST_OK : sst_pkg::ST_MISS;
            end
            sst_pkg::ACT_GET:
            begin
                if (found)
                begin
                    status_next = sst_pkg::ST_OK;
                    read_next   = sst_pkg::KEY_BITS'(found_key);
                end
            end
            default:
            begin
                status_next = sst_pkg::ST_MISS;
            end
        endcase
    end

    assign total_next     = sst_pkg::TOTAL_BITS'(count_next);
    assign out_valid_next = commit ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sst_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        key_reg <= key_next;
        if (commit)
        begin
            status_reg <= status_next;
            read_reg   <= read_next;
            total_reg  <= total_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.read_key    = read_reg;
    assign rsp.entry_total = total_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("count above capacity");

    a_occ_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        CW'($countones(cell_occ)) == count_reg)
        else $error("occupied cells disagree with count");

    a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp.valid)
        else $error("committed request gave no response");

    a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && status_next == sst_pkg::ST_FULL) |-> (count_reg == CAP_CNT))
        else $error("full status below capacity");

    a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.shift_up && ctl.shift_down) && !(ctl.capture && commit))
        else $error("conflicting cell commands");

endmodule
